// File: rtl/frame_deframer_fnv_check_unit_assert.svh
// Assertion macros used by the frame deframer RTL.
`ifndef FRAME_DEFRAMER_FNV_CHECK_UNIT_ASSERT_SVH
`define FRAME_DEFRAMER_FNV_CHECK_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define FDFC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define FDFC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FDFC_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define FDFC_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/fdfc_pkg.sv
// Shared types and constants of the frame deframer with FNV body check.
package fdfc_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MAGIC   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VERSION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEN = 2'd2;

    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    // Frame status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE  = 2'd2;
    localparam logic [1:0] ST_MISMATCH   = 2'd3;

    // Position of the final header byte.
    localparam logic [3:0] HDR_LAST = 4'd15;

    localparam logic [63:0] FNV_BASIS      = 64'hcbf29ce484222325;
    localparam logic [31:0] FNV_BASIS_FOLD = FNV_BASIS[31:0] ^ FNV_BASIS[63:32];

    localparam int M_TDATA_W = 64;

    // One registered input byte.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } item_t;

    // One result item.
    typedef struct packed {
        logic        has_data;
        logic [7:0]  body_byte;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [15:0] frame_type;
        logic [31:0] frame_length;
    } result_t;

endpackage

// File: rtl/frame_deframer_fnv_check_unit.sv
// Top level of the streaming frame deframer with folded FNV-1a body check.
// A result reaches m_tdata through the input register, then the result register.
// Throughput: one byte per cycle unless m_tready stalls, set by the FNV hash loop.
// Bytes that complete no result (most header bytes) leave no item on the m_ side.
// Reset (aresetn low at a clock edge) clears the stages, restarts header
// collection and loads the register defaults.
module frame_deframer_fnv_check_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [fdfc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fdfc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Received byte stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] body_byte, [9:8] frame_status, [25:10] frame_type,
    // [57:26] frame_length, [63:58] zero
    output logic [fdfc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,   // frame_end
    output logic                                 m_tuser    // [0] has_data
);
    import fdfc_pkg::*;

    item_t   item;
    logic    adv_ok;
    result_t res;

    fdfc_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .adv_ok   (adv_ok),
        .item     (item)
    );

    fdfc_frame_ctrl u_frame_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .adv_ok    (adv_ok),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result onto the stream ports.
    assign m_tdata = {6'd0, res.frame_length, res.frame_type, res.frame_status, res.body_byte};
    assign m_tlast = res.frame_end;
    assign m_tuser = res.has_data;

endmodule

// File: rtl/fdfc_in_reg.sv
// Input register stage that holds one received byte until it is processed.
module fdfc_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          adv_ok,
    output fdfc_pkg::item_t item
);
    import fdfc_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;

    // The register can take a new request when empty or when drained this cycle.
    assign s_tready = !valid_reg || adv_ok;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                data_next = s_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

// File: rtl/fdfc_fnv_step.sv
// One FNV-1a 64-bit update: xor in a byte, then multiply by the FNV prime.
module fdfc_fnv_step (
    input  logic [63:0] hash_in,
    input  logic [7:0]  byte_in,
    output logic [63:0] hash_out
);
    import fdfc_pkg::*;

    logic [63:0] mixed;

    // The prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
    assign mixed    = hash_in ^ {56'd0, byte_in};
    assign hash_out = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                    + (mixed << 4) + (mixed << 1) + mixed;

endmodule

// File: rtl/fdfc_frame_ctrl.sv
// Header collection, header checks, body hashing and the result register.
`include "frame_deframer_fnv_check_unit_assert.svh"

module fdfc_frame_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fdfc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fdfc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  fdfc_pkg::item_t                    item,
    output logic                               adv_ok,
    output logic                               res_valid,
    input  logic                               res_ready,
    output fdfc_pkg::result_t                  res
);
    import fdfc_pkg::*;

    // Configuration registers.
    logic [31:0] exp_magic_reg;
    logic [15:0] exp_version_reg;
    logic [31:0] max_len_reg;

    // Frame state.
    logic            in_body_reg, in_body_next;
    logic [3:0]      hdr_count_reg, hdr_count_next;
    logic [3:0][7:0] hdr_magic_reg, hdr_magic_next;
    logic [1:0][7:0] hdr_version_reg, hdr_version_next;
    logic [1:0][7:0] hdr_type_reg, hdr_type_next;
    logic [3:0][7:0] hdr_length_reg, hdr_length_next;
    logic [3:0][7:0] hdr_cks_reg, hdr_cks_next;
    logic [31:0]     bytes_left_reg, bytes_left_next;
    logic [63:0]     hash_reg, hash_next;

    // Result register.
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic        fire;
    logic        emit;
    result_t     cur;
    logic [63:0] hash_step;
    logic [31:0] cks_now;
    logic [31:0] fold_step;

    fdfc_fnv_step u_fnv (
        .hash_in  (hash_reg),
        .byte_in  (item.data),
        .hash_out (hash_step)
    );

    assign adv_ok    = !out_valid_reg || res_ready;
    assign fire      = item.valid && adv_ok;
    assign cks_now   = {item.data, hdr_cks_reg[2], hdr_cks_reg[1], hdr_cks_reg[0]};
    assign fold_step = hash_step[31:0] ^ hash_step[63:32];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_magic_reg   <= '0;
            exp_version_reg <= '0;
            max_len_reg     <= MAX_LEN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MAGIC:   exp_magic_reg   <= cfg_wdata;
                REG_VERSION: exp_version_reg <= cfg_wdata[15:0];
                REG_MAX_LEN: max_len_reg     <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Per-byte frame processing.
    always_comb begin
        in_body_next     = in_body_reg;
        hdr_count_next   = hdr_count_reg;
        hdr_magic_next   = hdr_magic_reg;
        hdr_version_next = hdr_version_reg;
        hdr_type_next    = hdr_type_reg;
        hdr_length_next  = hdr_length_reg;
        hdr_cks_next     = hdr_cks_reg;
        bytes_left_next  = bytes_left_reg;
        hash_next        = hash_reg;
        emit             = 1'b0;
        cur              = '0;
        cur.frame_type   = hdr_type_reg;
        cur.frame_length = hdr_length_reg;

        if (in_body_reg) begin
            // Body byte: forward it and advance the hash.
            hash_next       = hash_step;
            bytes_left_next = bytes_left_reg - 32'd1;
            emit            = 1'b1;
            cur.has_data    = 1'b1;
            cur.body_byte   = item.data;
            if (bytes_left_reg == 32'd1) begin
                in_body_next     = 1'b0;
                hdr_count_next   = '0;
                cur.frame_end    = 1'b1;
                cur.frame_status = (fold_step == hdr_cks_reg) ? ST_OK : ST_MISMATCH;
            end
        end else begin
            // Header byte: store it at its little-endian place.
            case (hdr_count_reg) inside
                [4'd0:4'd3]:   hdr_magic_next[hdr_count_reg[1:0]]  = item.data;
                [4'd4:4'd5]:   hdr_version_next[hdr_count_reg[0]]  = item.data;
                [4'd6:4'd7]:   hdr_type_next[hdr_count_reg[0]]     = item.data;
                [4'd8:4'd11]:  hdr_length_next[hdr_count_reg[1:0]] = item.data;
                default:       hdr_cks_next[hdr_count_reg[1:0]]    = item.data;
            endcase

            if (hdr_count_reg != HDR_LAST) begin
                hdr_count_next = hdr_count_reg + 4'd1;
            end else begin
                // Complete header: checks in order of priority.
                hdr_count_next = '0;
                hash_next      = FNV_BASIS;
                if (hdr_magic_reg != exp_magic_reg || hdr_version_reg != exp_version_reg) begin
                    emit             = 1'b1;
                    cur.frame_end    = 1'b1;
                    cur.frame_status = ST_BAD_HEADER;
                end else if (hdr_length_reg > max_len_reg) begin
                    emit             = 1'b1;
                    cur.frame_end    = 1'b1;
                    cur.frame_status = ST_TOO_LARGE;
                end else if (hdr_length_reg == 32'd0) begin
                    emit             = 1'b1;
                    cur.frame_end    = 1'b1;
                    cur.frame_status = (FNV_BASIS_FOLD == cks_now) ? ST_OK : ST_MISMATCH;
                end else begin
                    in_body_next    = 1'b1;
                    bytes_left_next = hdr_length_reg;
                end
            end
        end
    end

    // Result register: loaded when a byte is processed, emptied when taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (fire) begin
            out_valid_next = emit;
            out_next       = cur;
        end else if (res_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg   <= 1'b0;
            hdr_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (fire) begin
                in_body_reg   <= in_body_next;
                hdr_count_reg <= hdr_count_next;
            end
        end
        if (fire) begin
            hdr_magic_reg   <= hdr_magic_next;
            hdr_version_reg <= hdr_version_next;
            hdr_type_reg    <= hdr_type_next;
            hdr_length_reg  <= hdr_length_next;
            hdr_cks_reg     <= hdr_cks_next;
            bytes_left_reg  <= bytes_left_next;
            hash_reg        <= hash_next;
        end
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Checks on the frame state and the result register.
    `FDFC_ASSERT_IMP(a_body_left, aclk, aresetn, in_body_reg, bytes_left_reg != 32'd0, "body phase with no bytes left")
    `FDFC_ASSERT_IMP(a_body_count, aclk, aresetn, in_body_reg, hdr_count_reg == 4'd0, "header count not cleared in body phase")
    `FDFC_ASSERT_IMP(a_status_idle, aclk, aresetn, out_valid_reg && !out_reg.frame_end, out_reg.frame_status == ST_OK && out_reg.has_data, "result without frame end must be a plain body byte")
    `FDFC_ASSERT_NXT(a_hdr_silent, aclk, aresetn, fire && !in_body_reg && hdr_count_reg != HDR_LAST, !out_valid_reg, "header byte produced a result")

endmodule

// File: tb/frame_deframer_fnv_check_unit_test.sv
// Self-checking testbench of the frame deframer with folded FNV-1a body check.
`timescale 1ns / 1ps

module frame_deframer_fnv_check_unit_test;
    import fdfc_pkg::*;

    localparam logic [63:0] FNV_PRIME      = 64'h0000_0100_0000_01b3;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          LONG_HOLD      = 250;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          PHASE_BYTES    = 140;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]       cfg_addr  = REG_MAGIC;
    logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]        m_tdata;
    logic                        m_tlast;
    logic                        m_tuser;

    frame_deframer_fnv_check_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Stimulus and expectation stores.
    logic [7:0] pending_bytes[$];
    result_t    expected_results[$];
    int         mismatch_count = 0;
    int         bytes_queued   = 0;
    bit         no_gaps        = 1'b0;
    bit         byte_taken     = 1'b0;
    int         idle_cycles    = 0;
    int         hold_requests  = 0;
    int         hold_served    = 0;
    int         hold_left      = 0;

    // Predictor copy of the configuration registers.
    logic [31:0] want_magic   = 32'd0;
    logic [15:0] want_version = 16'd0;
    logic [31:0] len_limit    = MAX_LEN_RESET;

    // Predictor copy of the deframer state.
    bit          in_body_now  = 1'b0;
    logic [3:0]  hdr_pos      = 4'd0;
    logic [31:0] got_magic    = 32'd0;
    logic [15:0] got_version  = 16'd0;
    logic [15:0] got_type     = 16'd0;
    logic [31:0] got_length   = 32'd0;
    logic [31:0] got_checksum = 32'd0;
    logic [31:0] body_left    = 32'd0;
    logic [63:0] body_hash    = FNV_BASIS;

    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    function automatic logic [31:0] fold64(input logic [63:0] h);
        return h[31:0] ^ h[63:32];
    endfunction

    // Advance the deframer prediction by one accepted byte.
    function void predict_byte(input logic [7:0] b);
        result_t r;
        bit      produce;
        int      pos;
        r       = '0;
        produce = 1'b0;
        pos     = hdr_pos;
        if (in_body_now) begin
            body_hash  = fnv_mix(body_hash, b);
            body_left  = body_left - 32'd1;
            produce    = 1'b1;
            r.has_data = 1'b1;
            r.body_byte = b;
            if (body_left == 32'd0) begin
                in_body_now    = 1'b0;
                hdr_pos        = 4'd0;
                r.frame_end    = 1'b1;
                r.frame_status = (fold64(body_hash) == got_checksum) ? ST_OK : ST_MISMATCH;
            end
        end else begin
            if (pos < 4)
                got_magic[8*pos +: 8] = b;
            else if (pos < 6)
                got_version[8*(pos-4) +: 8] = b;
            else if (pos < 8)
                got_type[8*(pos-6) +: 8] = b;
            else if (pos < 12)
                got_length[8*(pos-8) +: 8] = b;
            else
                got_checksum[8*(pos-12) +: 8] = b;

            if (hdr_pos != HDR_LAST) begin
                hdr_pos = hdr_pos + 4'd1;
            end else begin
                // Header complete: magic and version first, then the length.
                hdr_pos     = 4'd0;
                body_hash   = FNV_BASIS;
                produce     = 1'b1;
                r.frame_end = 1'b1;
                if (got_magic != want_magic || got_version != want_version) begin
                    r.frame_status = ST_BAD_HEADER;
                end else if (got_length > len_limit) begin
                    r.frame_status = ST_TOO_LARGE;
                end else if (got_length == 32'd0) begin
                    r.frame_status = (fold64(body_hash) == got_checksum) ? ST_OK : ST_MISMATCH;
                end else begin
                    produce     = 1'b0;
                    in_body_now = 1'b1;
                    body_left   = got_length;
                end
            end
        end
        r.frame_type   = got_type;
        r.frame_length = got_length;
        if (produce)
            expected_results = {expected_results, r};
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatch_count++;
        end
    endfunction

    // Byte stream driver: holds a request until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !byte_taken) begin
            s_tvalid <= 1'b1;
        end else if (pending_bytes.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 36)) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pending_bytes.pop_front();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result receiver with random stalls and an occasional long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready    <= 1'b0;
            hold_left   <= LONG_HOLD - 1;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= no_gaps || ($urandom_range(0, 99) >= 36);
        end
    end

    // Prediction on accepted bytes, checking of accepted results, and the watchdog.
    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        byte_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata);

            if (m_tvalid && m_tready) begin
                seen.has_data     = m_tuser;
                seen.body_byte    = m_tdata[7:0];
                seen.frame_end    = m_tlast;
                seen.frame_status = m_tdata[9:8];
                seen.frame_type   = m_tdata[25:10];
                seen.frame_length = m_tdata[57:26];
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: tdata 0x%0h tlast %0b tuser %0b",
                           m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("has_data", 32'(want.has_data), 32'(seen.has_data));
                    compare_field("body_byte", 32'(want.body_byte), 32'(seen.body_byte));
                    compare_field("frame_end", 32'(want.frame_end), 32'(seen.frame_end));
                    compare_field("frame_status", 32'(want.frame_status),
                                  32'(seen.frame_status));
                    compare_field("frame_type", 32'(want.frame_type), 32'(seen.frame_type));
                    compare_field("frame_length", want.frame_length, seen.frame_length);
                end
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Wait until every byte is taken and every result has arrived, then let the pipe settle.
    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        #1;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAGIC:   want_magic   = value;
            REG_VERSION: want_version = value[15:0];
            REG_MAX_LEN: len_limit    = value;
            default: ;
        endcase
        @(posedge aclk);
        #1;
    endtask

    // Queue one frame: little-endian header, then body_count random body bytes.
    task automatic queue_frame(input logic [31:0] magic, input logic [15:0] ver,
                               input logic [15:0] ftype, input logic [31:0] len,
                               input int body_count, input bit bad_sum);
        logic [7:0]   body[$];
        logic [63:0]  h;
        logic [31:0]  sum;
        logic [127:0] hdr;
        h = FNV_BASIS;
        repeat (body_count) begin
            body = {body, 8'($urandom_range(0, 255))};
            h = fnv_mix(h, body[$]);
        end
        sum = fold64(h);
        if (bad_sum)
            sum = sum ^ ($urandom | 32'd1);
        hdr = {sum, len, ftype, ver, magic};
        for (int i = 0; i < 16; i++)
            pending_bytes = {pending_bytes, hdr[8*i +: 8]};
        foreach (body[i])
            pending_bytes = {pending_bytes, body[i]};
        bytes_queued += 16 + body_count;
    endtask

    // Mostly well-formed frames, with corrupt checksums and broken headers mixed in.
    task automatic queue_random_frame();
        int          kind;
        int          cap;
        logic [31:0] len;
        logic [31:0] big_len;
        logic [15:0] ftype;
        kind  = $urandom_range(0, 99);
        ftype = $urandom_range(0, 65535);
        cap   = (len_limit < 32'd24) ? int'(len_limit) : 24;
        if (len_limit >= 32'd64 && $urandom_range(0, 11) == 0)
            cap = 64;
        len = $urandom_range(0, cap);
        if (kind >= 88 && len_limit == 32'hFFFF_FFFF)
            kind = 80;
        if (kind < 60) begin
            queue_frame(want_magic, want_version, ftype, len, len, 1'b0);
        end else if (kind < 70) begin
            queue_frame(want_magic, want_version, ftype, len, len, 1'b1);
        end else if (kind < 80) begin
            queue_frame(want_magic ^ ($urandom | 32'd1), $urandom_range(0, 65535), ftype,
                        $urandom, 0, $urandom_range(0, 1));
        end else if (kind < 88) begin
            queue_frame(want_magic, want_version ^ $urandom_range(1, 65535), ftype,
                        $urandom, 0, 1'b0);
        end else begin
            big_len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                  : len_limit + 32'd1 + $urandom_range(0, 1000);
            queue_frame(want_magic, want_version, ftype, big_len, 0, 1'b0);
        end
    endtask

    initial begin
        logic [127:0] split_hdr;
        int           start_bytes;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        // Reset defaults: zero-length frames, short bodies, header errors.
        queue_frame(32'd0, 16'd0, 16'hFFFF, 32'd0, 0, 1'b0);
        queue_frame(32'd0, 16'd0, 16'h0000, 32'd0, 0, 1'b1);
        queue_frame(32'd0, 16'd0, 16'h1234, 32'd1, 1, 1'b0);
        queue_frame(32'd0, 16'd0, 16'h00FF, 32'd3, 3, 1'b1);
        queue_frame(32'hFFFF_FFFF, 16'd0, 16'h8001, 32'd0, 0, 1'b0);
        queue_frame(32'd0, 16'hFFFF, 16'h0100, 32'd2, 0, 1'b0);
        queue_frame(32'd0, 16'd0, 16'h7FFE, MAX_LEN_RESET + 32'd1, 0, 1'b0);
        // A wrong magic wins over an oversized length.
        queue_frame(32'd1, 16'd0, 16'h4242, 32'hFFFF_FFFF, 0, 1'b0);
        wait_idle();

        // All-ones identity with a zero length limit.
        write_reg(REG_MAGIC, 32'hFFFF_FFFF);
        write_reg(REG_VERSION, 32'h0000_FFFF);
        write_reg(REG_MAX_LEN, 32'd0);
        queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h0001, 32'd0, 0, 1'b0);
        queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h0002, 32'd1, 0, 1'b0);
        wait_idle();

        // Length equal to the limit passes, one above it does not.
        write_reg(REG_MAX_LEN, 32'd5);
        queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h0003, 32'd5, 5, 1'b0);
        queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h0004, 32'd6, 0, 1'b0);

        // Registers are taken only at the last header byte: change the version mid-header.
        split_hdr = {FNV_BASIS_FOLD, 32'd0, 16'h5A5A, 16'hA5A5, 32'hFFFF_FFFF};
        for (int i = 0; i < 8; i++)
            pending_bytes = {pending_bytes, split_hdr[8*i +: 8]};
        wait_idle();
        write_reg(REG_VERSION, 32'h0000_A5A5);
        for (int i = 8; i < 16; i++)
            pending_bytes = {pending_bytes, split_hdr[8*i +: 8]};
        wait_idle();

        write_reg(REG_MAX_LEN, 32'hFFFF_FFFF);
        queue_frame(32'hFFFF_FFFF, 16'h1234, 16'h0005, 32'hFFFF_FFFF, 0, 1'b0);
        queue_frame(32'hFFFF_FFFF, 16'hA5A5, 16'h0006, 32'd2, 2, 1'b0);
        wait_idle();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_MAGIC, $urandom);
                    write_reg(REG_VERSION, $urandom_range(0, 65535));
                    write_reg(REG_MAX_LEN, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(REG_MAGIC, 32'd0);
                    write_reg(REG_VERSION, 32'h0000_FFFF);
                    write_reg(REG_MAX_LEN, $urandom_range(8, 30));
                    // Receiver holds off while the byte stream keeps coming.
                    hold_requests++;
                end
                2: begin
                    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
                    write_reg(REG_VERSION, 32'd0);
                    write_reg(REG_MAX_LEN, 32'd0);
                end
                default: begin
                    write_reg(REG_MAGIC, $urandom);
                    write_reg(REG_VERSION, $urandom_range(0, 65535));
                    write_reg(REG_MAX_LEN, MAX_LEN_RESET);
                end
            endcase
            no_gaps     = (phase == 2);
            start_bytes = bytes_queued;
            while (bytes_queued - start_bytes < PHASE_BYTES)
                queue_random_frame();
            wait_idle();
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
